// File: rtl/sha1md_pkg.sv
// shared types and constants for the sha-1 digest block
`default_nettype none
package sha1md_pkg;
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hc3d2e1f0;
  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  function automatic logic [31:0] iv_word(input logic [2:0] i);
    case (i)
      3'd0: iv_word = IV0;
      3'd1: iv_word = IV1;
      3'd2: iv_word = IV2;
      3'd3: iv_word = IV3;
      default: iv_word = IV4;
    endcase
  endfunction
endpackage
`default_nettype wire

// File: rtl/sha1md_if.sv
// valid/ready channel interface
`default_nettype none
interface sha1md_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/sha1md_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module sha1md_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/sha1md_round.sv
// one sha-1 round: working register update
`default_nettype none
module sha1md_round (
  input  wire logic [6:0]   t,
  input  wire logic [31:0]  w,
  input  wire logic [159:0] abcde,
  output      logic [159:0] abcde_next
);
  logic [31:0] a, b, c, d, e, f, k, tmp;
  always_comb begin
    {a, b, c, d, e} = abcde;
    if (t < 7'd20) begin
      f = (b & c) | (~b & d);
      k = sha1md_pkg::K0;
    end else if (t < 7'd40) begin
      f = b ^ c ^ d;
      k = sha1md_pkg::K1;
    end else if (t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = sha1md_pkg::K2;
    end else begin
      f = b ^ c ^ d;
      k = sha1md_pkg::K3;
    end
    tmp = {a[26:0], a[31:27]} + f + e + k + w;
    abcde_next = {tmp, a, {b[1:0], b[31:2]}, c, d};
  end
endmodule
`default_nettype wire

// File: rtl/sha1_message_digest_top.sv
// sha-1 digest top level: byte packing, schedule memory, round sequencer
`default_nettype none
// usage
// - in: one request per message byte {msg_byte, has_byte, is_last}
// - out: five requests per message, digest words 0..4, last_word on word 4
// - bytes are packed big-endian into a 16-word block memory; each byte
//   goes through accept, read word and write merged word
// - a full block runs 80 rounds; the schedule lives in the same 16-entry
//   memory; rounds 0..15 read w[t], then update; rounds 16..79
//   read w[t-3], w[t-8], w[t-14], w[t-16] one per cycle and write w[t] back
//   with the update; a block also passes load, add and hand-off steps;
//   the single memory read port sets this sequence
// - on is_last the block writes the pad byte, zero fill and length,
//   runs one or two compressions, then offers the five words, one per
//   cycle when the receiver is ready
// - in.ready is high only while idle
// - an output stall holds the word index, so the current word stays on out.data
// - rst (synchronous, active high) restores the initial vector and
//   clears the byte count; block memory contents are don't-care since
//   every word is written before it is read
module sha1_message_digest_top (
  input wire logic clk,
  input wire logic rst,
  sha1md_if.sink   in,
  sha1md_if.source out
);
  typedef enum logic [3:0] {
    S_IDLE, S_BRD, S_BWR, S_PAD, S_LEN, S_CINIT, S_RD, S_RUN, S_ADD,
    S_POST, S_OUT
  } st_t;
  st_t st;

  logic [159:0] chain, work, work_next;
  logic [60:0]  cnt;
  logic [6:0]   t;
  logic [1:0]   ph;
  logic [31:0]  acc;
  logic [7:0]   bval;
  logic         last_p, second, late;
  logic [3:0]   padi;
  logic [2:0]   oi;

  logic        we;
  logic [3:0]  waddr, raddr;
  logic [31:0] wdata, rdata;
  sha1md_ram #(.Width(32), .Depth(16)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [31:0] wr_t;
  sha1md_round u_round (.t(t), .w(wr_t), .abcde(work), .abcde_next(work_next));

  logic [5:0]  pos;
  logic [1:0]  bi;
  logic [31:0] merged, mixed;
  logic [63:0] bits;
  assign pos = cnt[5:0];
  assign bi = pos[1:0];
  assign bits = {cnt, 3'b000};
  assign mixed = acc ^ rdata;
  assign wr_t = (t < 7'd16) ? rdata : {mixed[30:0], mixed[31]};

  always_comb begin
    merged = rdata;
    case (bi)
      2'd0: merged = {bval, 24'h0};
      2'd1: merged = {rdata[31:24], bval, 16'h0};
      2'd2: merged = {rdata[31:16], bval, 8'h0};
      default: merged = {rdata[31:8], bval};
    endcase
  end

  // read address: byte word, w[t] for rounds 0..15, or schedule taps t-3,t-8,t-14,t-16 mod 16,
  // one per cycle, the data arriving from the registered read in the following cycle
  always_comb begin
    raddr = pos[5:2];
    if (st == S_RD) begin
      raddr = (t < 7'd16) ? t[3:0] : t[3:0] - 4'd3;
    end else if (st == S_RUN) begin
      case (ph)
        2'd0: raddr = t[3:0] - 4'd8;
        2'd1: raddr = t[3:0] - 4'd14;
        default: raddr = t[3:0];
      endcase
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = pos[5:2];
    wdata = merged;
    case (st)
      S_BWR: we = 1'b1;
      S_PAD: begin
        we = 1'b1; waddr = padi; wdata = 32'h0;
      end
      S_LEN: begin
        we = 1'b1; waddr = padi; wdata = padi[0] ? bits[31:0] : bits[63:32];
      end
      S_RUN: begin
        we = (ph == 2'd3); waddr = t[3:0]; wdata = wr_t;
      end
      default: we = 1'b0;
    endcase
  end

  assign in.ready = (st == S_IDLE);
  assign out.valid = (st == S_OUT);
  always_comb begin
    case (oi)
      3'd0: out.data.digest_word = chain[159:128];
      3'd1: out.data.digest_word = chain[127:96];
      3'd2: out.data.digest_word = chain[95:64];
      3'd3: out.data.digest_word = chain[63:32];
      default: out.data.digest_word = chain[31:0];
    endcase
    out.data.word_index = oi;
    out.data.last_word = (oi == 3'd4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      chain <= {sha1md_pkg::iv_word(3'd0), sha1md_pkg::iv_word(3'd1),
                sha1md_pkg::iv_word(3'd2), sha1md_pkg::iv_word(3'd3),
                sha1md_pkg::iv_word(3'd4)};
      cnt <= '0;
      oi <= '0;
      last_p <= 1'b0;
      second <= 1'b0;
      late <= 1'b0;
    end else begin
      case (st)
        S_IDLE: if (in.valid) begin
          last_p <= in.data.is_last;
          if (in.data.has_byte) begin
            bval <= in.data.msg_byte;
            st <= S_BRD;
          end else if (in.data.is_last) begin
            bval <= sha1md_pkg::PAD_BYTE;
            second <= 1'b1;
            st <= S_BRD;
          end
        end
        S_BRD: st <= S_BWR;
        S_BWR: begin
          padi <= pos[5:2] + 4'd1;
          if (second) begin
            // pad byte placed; zero the rest, length here or in an extra block
            late <= (pos >= 6'd56);
            if (pos[5:2] == 4'd15) st <= S_CINIT;
            else if (pos[5:2] == 4'd13) begin
              padi <= 4'd14; st <= S_LEN;
            end else st <= S_PAD;
          end else begin
            cnt <= cnt + 61'd1;
            if (pos == 6'd63) st <= S_CINIT;
            else if (last_p) begin
              bval <= sha1md_pkg::PAD_BYTE; second <= 1'b1; st <= S_BRD;
            end else st <= S_IDLE;
          end
        end
        S_PAD: begin
          padi <= padi + 4'd1;
          if (!late && padi == 4'd13) begin
            padi <= 4'd14; st <= S_LEN;
          end else if (padi == 4'd15) st <= S_CINIT;
        end
        S_LEN: begin
          padi <= padi + 4'd1;
          if (padi == 4'd15) st <= S_CINIT;
        end
        S_CINIT: begin
          work <= chain; t <= '0; ph <= '0; st <= S_RD;
        end
        S_RD: begin
          // rounds 0..15 read w[t] directly, later rounds walk the four taps
          ph <= (t < 7'd16) ? 2'd3 : 2'd0;
          st <= S_RUN;
        end
        S_RUN: begin
          if (ph == 2'd3) begin
            work <= work_next;
            acc <= '0;
            if (t == 7'd79) st <= S_ADD;
            else begin
              t <= t + 7'd1; ph <= 2'd0; st <= S_RD;
            end
          end else begin
            acc <= acc ^ rdata;
            ph <= ph + 2'd1;
          end
        end
        S_ADD: begin
          chain <= {chain[159:128] + work[159:128], chain[127:96] + work[127:96],
                    chain[95:64] + work[95:64], chain[63:32] + work[63:32],
                    chain[31:0] + work[31:0]};
          st <= S_POST;
        end
        S_POST: begin
          if (!second) begin
            if (last_p) begin
              bval <= sha1md_pkg::PAD_BYTE; second <= 1'b1; st <= S_BRD;
            end else st <= S_IDLE;
          end else if (late) begin
            // length did not fit: a fresh block of zeros plus the length
            late <= 1'b0;
            padi <= 4'd0;
            st <= S_PAD;
          end else begin
            oi <= '0; st <= S_OUT;
          end
        end
        S_OUT: if (out.ready) begin
          oi <= oi + 3'd1;
          if (oi == 3'd4) begin
            st <= S_IDLE;
            chain <= {sha1md_pkg::iv_word(3'd0), sha1md_pkg::iv_word(3'd1),
                      sha1md_pkg::iv_word(3'd2), sha1md_pkg::iv_word(3'd3),
                      sha1md_pkg::iv_word(3'd4)};
            cnt <= '0; second <= 1'b0; last_p <= 1'b0;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: dv/sha1_message_digest_top_tb.sv
// testbench for the sha-1 digest block: byte stream in, checked digest words out
module sha1_message_digest_top_tb;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  sha1md_if #(.T(sha1md_pkg::in_t))  in_ch();
  sha1md_if #(.T(sha1md_pkg::out_t)) out_ch();

  sha1_message_digest_top u_top (
    .clk(clk),
    .rst(rst),
    .in(in_ch.sink),
    .out(out_ch.source)
  );

  // predictor state: chaining value, partial block, byte count
  logic [31:0] hash_state[5];
  logic [31:0] msg_block[16];
  logic [60:0] msg_len;

  sha1md_pkg::in_t  pending_bytes[$];
  sha1md_pkg::out_t digest_queue[$];
  int   mismatch_count = 0;
  int   stim_mode = 1;
  bit   in_fire = 1'b0;
  bit   out_fire = 1'b0;
  int   send_gap = 0;
  int   sink_gap = 0;

  function automatic logic [31:0] rol(input logic [31:0] v, input int r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic void digest_init();
    hash_state[0] = sha1md_pkg::IV0;
    hash_state[1] = sha1md_pkg::IV1;
    hash_state[2] = sha1md_pkg::IV2;
    hash_state[3] = sha1md_pkg::IV3;
    hash_state[4] = sha1md_pkg::IV4;
    foreach (msg_block[i]) msg_block[i] = '0;
    msg_len = '0;
  endfunction

  function automatic void run_rounds();
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = msg_block[i];
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2];
    d = hash_state[3]; e = hash_state[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = sha1md_pkg::K0;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = sha1md_pkg::K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = sha1md_pkg::K2;
      end else begin
        f = b ^ c ^ d; k = sha1md_pkg::K3;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
    hash_state[3] += d; hash_state[4] += e;
  endfunction

  function automatic void place_byte(input int pos, input logic [7:0] v);
    msg_block[pos / 4][(3 - pos % 4) * 8 +: 8] = v;
  endfunction

  // absorb one request; queue five words when it ends a message
  function automatic void hash_request(input sha1md_pkg::in_t req);
    int pos;
    logic [63:0] bit_len;
    sha1md_pkg::out_t w;
    if (req.has_byte) begin
      pos = int'(msg_len[5:0]);
      place_byte(pos, req.msg_byte);
      msg_len = msg_len + 61'd1;
      if (pos == 63) run_rounds();
    end
    if (!req.is_last) return;
    // padding: 0x80, zero fill, and a second block when no room for the length
    pos = int'(msg_len[5:0]);
    place_byte(pos, sha1md_pkg::PAD_BYTE);
    for (int i = pos + 1; i < 64; i++) place_byte(i, 8'h00);
    if (pos >= 56) begin
      run_rounds();
      foreach (msg_block[i]) msg_block[i] = '0;
    end
    bit_len = {msg_len, 3'b000};
    msg_block[14] = bit_len[63:32];
    msg_block[15] = bit_len[31:0];
    run_rounds();
    for (int i = 0; i < 5; i++) begin
      w.digest_word = hash_state[i];
      w.word_index  = 3'(i);
      w.last_word   = (i == 4);
      digest_queue = {digest_queue, w};
    end
    digest_init();
  endfunction

  function automatic sha1md_pkg::in_t mk_req(input logic [7:0] b, input bit hb,
                                             input bit lst);
    sha1md_pkg::in_t r;
    r.msg_byte = b; r.has_byte = hb; r.is_last = lst;
    return r;
  endfunction

  // message of n random bytes; ends with or without a byte
  task automatic queue_message(input int n);
    bit end_with_byte;
    end_with_byte = (n > 0) && $urandom_range(0, 1);
    for (int i = 0; i < n; i++) begin
      // occasional idle request inside the message
      if ($urandom_range(0, 15) == 0)
        pending_bytes = {pending_bytes, mk_req(8'($urandom), 1'b0, 1'b0)};
      pending_bytes = {pending_bytes,
                       mk_req(8'($urandom), 1'b1, end_with_byte && i == n - 1)};
    end
    if (!end_with_byte)
      pending_bytes = {pending_bytes, mk_req(8'($urandom), 1'b0, 1'b1)};
  endtask

  // accepted requests feed the predictor
  always @(posedge clk) begin
    in_fire <= !rst && in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready) begin
      hash_request(in_ch.data);
    end
  end

  // driver: a fresh gap per request, data changes on the falling edge
  always @(negedge clk) begin
    int gap_now;
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
      send_gap    <= 0;
    end else if (in_fire || !in_ch.valid) begin
      if (in_fire) gap_now = (stim_mode == 0) ? 0 : int'($urandom_range(0, 17));
      else gap_now = send_gap;
      if (gap_now == 0 && pending_bytes.size() > 0) begin
        in_ch.data  <= pending_bytes.pop_front();
        in_ch.valid <= 1'b1;
        send_gap    <= 0;
      end else begin
        in_ch.valid <= 1'b0;
        send_gap    <= (gap_now > 0) ? gap_now - 1 : 0;
      end
    end
  end

  // sink side: ready stalls drawn per word
  always @(negedge clk) begin
    int gap_now;
    if (rst) begin
      out_ch.ready <= 1'b0;
      sink_gap     <= 0;
    end else begin
      if (out_fire) gap_now = (stim_mode == 0) ? 0 : int'($urandom_range(0, 17));
      else gap_now = sink_gap;
      if (gap_now > 0) begin
        out_ch.ready <= 1'b0;
        sink_gap     <= gap_now - 1;
      end else begin
        out_ch.ready <= 1'b1;
        sink_gap     <= 0;
      end
    end
  end

  // monitor: compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    sha1md_pkg::out_t got, want;
    out_fire <= !rst && out_ch.valid && out_ch.ready;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (digest_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected digest word %h idx %0d", got.digest_word, got.word_index);
      end else begin
        want = digest_queue.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                     want.digest_word, want.word_index, want.last_word,
                     got.digest_word, got.word_index, got.last_word);
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    digest_init();
    // directed: idle request, empty message, one-byte extremes, and abc
    pending_bytes = {pending_bytes, mk_req(8'hff, 1'b0, 1'b0)};
    pending_bytes = {pending_bytes, mk_req(8'h00, 1'b0, 1'b1)};
    pending_bytes = {pending_bytes, mk_req(8'hff, 1'b1, 1'b1)};
    pending_bytes = {pending_bytes, mk_req(8'h00, 1'b1, 1'b1)};
    pending_bytes = {pending_bytes, mk_req(8'h61, 1'b1, 1'b0)};
    pending_bytes = {pending_bytes, mk_req(8'h62, 1'b1, 1'b0)};
    pending_bytes = {pending_bytes, mk_req(8'h63, 1'b1, 1'b1)};
    // no-stall stretch with the directed requests
    stim_mode = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (pending_bytes.size() != 0 || digest_queue.size() != 0) @(posedge clk);
    stim_mode = 1;
    // lengths around the 56 and 64 byte padding edges
    queue_message(55);
    queue_message(56);
    queue_message(63);
    queue_message(64);
    // random messages, mostly short, occasionally a multi-block one
    while (pending_bytes.size() < 410) begin
      if ($urandom_range(0, 9) == 0) queue_message($urandom_range(57, 130));
      else queue_message($urandom_range(0, 20));
    end
    while (pending_bytes.size() != 0 || in_ch.valid) @(posedge clk);
    while (digest_queue.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (mismatch_count == 0 && digest_queue.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // generous fixed limit: over 410 requests, block compressions and random stalls
  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
